// ===== rtl/core/hsss_pkg.sv =====
// hsss_pkg: shared types, constants and the half-step coil table for the
// half-step stepper sequencer. No dependencies.
package hsss_pkg;

  localparam int STEP_COUNT_BITS = 16;
  localparam int STEP_IN_W       = 16;
  localparam int DELAY_W         = 16;
  localparam int COIL_W          = 4;
  localparam int PHASE_W         = 3;
  localparam int DIR_W           = 2;

  localparam logic [DELAY_W-1:0] STEP_DELAY_RESET = DELAY_W'(100);
  localparam logic [PHASE_W-1:0] LAST_PHASE       = PHASE_W'(7);

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_FWD  = 4'b0010,
    SEQ_REV  = 4'b0100,
    SEQ_WAIT = 4'b1000
  } seq_state_t;

  typedef struct packed {
    seq_state_t                 seq;
    logic [PHASE_W-1:0]         phase;
    logic [STEP_COUNT_BITS-1:0] steps_left;
    logic [DELAY_W-1:0]         wait_count;
    logic                       resume_reverse;
    logic [DIR_W-1:0]           pending_dir;
    logic [STEP_COUNT_BITS-1:0] pending_steps;
    logic                       busy;
    logic [COIL_W-1:0]          coil;
  } seq_regs_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil_drive;
    logic              busy_res;
    logic              cmd_rejected;
    logic              step_taken;
  } step_result_t;

  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h5;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'hA;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/core/half_step_stepper_sequencer.sv =====
// half_step_stepper_sequencer: top level, input register, sequencer state and
// result register. Depends on hsss_pkg and hsss_step_core.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     kind, direction, step_count
//   out      out_valid / out_stall   coil_drive, busy_res, cmd_rejected, step_taken
//   cfg      cfg_valid / cfg_ready   cfg_data (step_delay)
//
// one item per cycle unless out_stall holds; items pass input, then result register
// rst is synchronous and returns the sequencer to idle, coils off, step_delay 100
// a stalled result holds the input register; in_stall rises only when both are full
// cfg_ready is always high
module half_step_stepper_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [hsss_pkg::DIR_W-1:0]         direction,
  input  logic [hsss_pkg::STEP_IN_W-1:0]     step_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hsss_pkg::COIL_W-1:0]        coil_drive,
  output logic                               busy_res,
  output logic                               cmd_rejected,
  output logic                               step_taken,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hsss_pkg::DELAY_W-1:0]       cfg_data
);

  logic                               s1_valid;
  logic                               s1_kind;
  logic [hsss_pkg::DIR_W-1:0]         s1_direction;
  logic [hsss_pkg::STEP_IN_W-1:0]     s1_step_count;
  logic [hsss_pkg::DELAY_W-1:0]       step_delay;
  hsss_pkg::seq_regs_t                regs;
  hsss_pkg::seq_regs_t                regs_next;
  hsss_pkg::step_result_t             res_next;
  logic                               advance;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  hsss_step_core u_core (
    .cur        (regs),
    .kind       (s1_kind),
    .direction  (s1_direction),
    .step_count (s1_step_count),
    .step_delay (step_delay),
    .nxt        (regs_next),
    .res        (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_kind       <= kind;
      s1_direction  <= direction;
      s1_step_count <= step_count;
    end
  end

  // sequencer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay          <= hsss_pkg::STEP_DELAY_RESET;
      regs.seq            <= hsss_pkg::SEQ_IDLE;
      regs.phase          <= '0;
      regs.steps_left     <= '0;
      regs.wait_count     <= '0;
      regs.resume_reverse <= 1'b0;
      regs.pending_dir    <= hsss_pkg::DIR_NONE;
      regs.pending_steps  <= '0;
      regs.busy           <= 1'b0;
      regs.coil           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_delay <= cfg_data;
      end
      if (s1_valid && advance) begin
        regs <= regs_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_valid && advance) begin
      coil_drive   <= res_next.coil_drive;
      busy_res     <= res_next.busy_res;
      cmd_rejected <= res_next.cmd_rejected;
      step_taken   <= res_next.step_taken;
    end
  end

endmodule

// ===== rtl/core/hsss_step_core.sv =====
// hsss_step_core: next-state and result logic for one item (tick or command).
// Depends on hsss_pkg.
module hsss_step_core (
  input  hsss_pkg::seq_regs_t                 cur,
  input  logic                                kind,
  input  logic [hsss_pkg::DIR_W-1:0]          direction,
  input  logic [hsss_pkg::STEP_IN_W-1:0]      step_count,
  input  logic [hsss_pkg::DELAY_W-1:0]        step_delay,
  output hsss_pkg::seq_regs_t                 nxt,
  output hsss_pkg::step_result_t              res
);

  localparam int CntW = hsss_pkg::STEP_COUNT_BITS;
  localparam int InW  = hsss_pkg::STEP_IN_W;

  logic [CntW-1:0] cnt_sat;
  logic [CntW-1:0] steps_dec;
  logic            dir_ok;
  logic            rejected;
  logic            stepped;

  // saturate the requested count to the counter width
  if (CntW >= InW) begin : g_cnt_wide
    assign cnt_sat = CntW'(step_count);
  end else begin : g_cnt_narrow
    assign cnt_sat = ((step_count >> CntW) != '0) ? '1 : step_count[CntW-1:0];
  end

  assign dir_ok    = (direction == hsss_pkg::DIR_FWD) || (direction == hsss_pkg::DIR_REV);
  assign steps_dec = (cur.steps_left != '0) ? cur.steps_left - CntW'(1) : '0;

  always_comb begin
    nxt      = cur;
    rejected = 1'b0;
    stepped  = 1'b0;
    if (kind == hsss_pkg::KIND_CMD) begin
      if (!dir_ok || (cnt_sat == '0) || cur.busy) begin
        rejected = 1'b1;
      end else begin
        nxt.busy          = 1'b1;
        nxt.pending_dir   = direction;
        nxt.pending_steps = cnt_sat;
      end
    end else begin
      unique case (cur.seq)
        hsss_pkg::SEQ_IDLE: begin
          if ((cur.pending_dir == hsss_pkg::DIR_FWD) ||
              (cur.pending_dir == hsss_pkg::DIR_REV)) begin
            if (cur.pending_steps != '0) begin
              nxt.steps_left = cur.pending_steps;
              nxt.seq        = (cur.pending_dir == hsss_pkg::DIR_FWD) ?
                               hsss_pkg::SEQ_FWD : hsss_pkg::SEQ_REV;
              nxt.busy       = 1'b1;
            end else begin
              nxt.busy = 1'b0;
            end
          end
          nxt.pending_dir   = hsss_pkg::DIR_NONE;
          nxt.pending_steps = '0;
        end
        hsss_pkg::SEQ_FWD, hsss_pkg::SEQ_REV: begin
          nxt.coil       = hsss_pkg::coil_pattern(cur.phase);
          nxt.phase      = (cur.seq == hsss_pkg::SEQ_FWD) ?
                           cur.phase + hsss_pkg::PHASE_W'(1) :
                           cur.phase + hsss_pkg::LAST_PHASE;
          stepped        = 1'b1;
          nxt.steps_left = steps_dec;
          if (steps_dec == '0) begin
            nxt.seq  = hsss_pkg::SEQ_IDLE;
            nxt.busy = 1'b0;
          end else begin
            nxt.resume_reverse = (cur.seq == hsss_pkg::SEQ_REV);
            nxt.wait_count     = '0;
            nxt.seq            = hsss_pkg::SEQ_WAIT;
          end
        end
        hsss_pkg::SEQ_WAIT: begin
          if (cur.wait_count >= step_delay) begin
            nxt.wait_count = '0;
            nxt.seq        = cur.resume_reverse ? hsss_pkg::SEQ_REV : hsss_pkg::SEQ_FWD;
          end else begin
            nxt.wait_count = cur.wait_count + hsss_pkg::DELAY_W'(1);
          end
        end
        default: begin
          nxt.seq = hsss_pkg::SEQ_IDLE;
        end
      endcase
    end
  end

  assign res.coil_drive   = nxt.coil;
  assign res.busy_res     = nxt.busy;
  assign res.cmd_rejected = rejected;
  assign res.step_taken   = stepped;

endmodule
